@@ rtl/core/dbsu_pkg.sv @@
package dbsu_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_W = 32;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int IDX_W = $clog2(MAX_ELEMENTS);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

endpackage

@@ rtl/core/descending_bubble_sort_unit.sv @@
// Loading takes one cycle per input beat; the unit stays ready until the beat marked last.
// Sorting takes up to n-1 passes; each reads elements 0 and 1, compares and writes back up to
// L, its last index, then stores the carry at L. It stops early after a pass with no swap.
// Each result beat is read from the single-port-read memory in ST_ORD, then offered in ST_OSEND.
// Reset is asynchronous and active low. It clears the control state but not the element memory.
module descending_bubble_sort_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 ready,
	input  dbsu_pkg::data_t      value,
	input  logic                 last,
	output logic                 res_valid,
	input  logic                 res_ready,
	output dbsu_pkg::data_t      value_res,
	output logic                 last_res,
	output logic                 overflow
);
	import dbsu_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD0,
		ST_RD1,
		ST_CMP,
		ST_PEND,
		ST_ORD,
		ST_OSEND
	} state_t;

	state_t state_q;
	cnt_t   cnt_q;
	logic   ovf_q;
	logic   swapped_q;
	idx_t   pos_q;
	idx_t   lim_q;
	idx_t   k_q;
	data_t  carry_q;
	data_t  rd_q;

	data_t  mem [MAX_ELEMENTS];

	logic   we;
	idx_t   waddr;
	data_t  wdata;
	idx_t   raddr;
	logic   in_beat;
	logic   store_ok;
	logic   do_swap;
	cnt_t   cnt_next;

	assign in_beat  = valid && ready;
	assign store_ok = cnt_q < CNT_W'(MAX_ELEMENTS);
	assign do_swap  = carry_q < rd_q;
	assign cnt_next = store_ok ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = carry_q;
		raddr = k_q;
		unique case (state_q)
			ST_LOAD: begin
				we    = in_beat && store_ok;
				waddr = cnt_q[IDX_W-1:0];
				wdata = value;
			end
			ST_RD0: begin
				raddr = '0;
			end
			ST_RD1: begin
				raddr = IDX_W'(1);
			end
			ST_CMP: begin
				we    = 1'b1;
				waddr = pos_q - IDX_W'(1);
				wdata = do_swap ? rd_q : carry_q;
				raddr = pos_q + IDX_W'(1);
			end
			ST_PEND: begin
				we    = 1'b1;
				waddr = lim_q;
				wdata = carry_q;
			end
			ST_ORD, ST_OSEND: begin
				raddr = k_q;
			end
			default: begin
				raddr = k_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			swapped_q <= 1'b0;
			pos_q     <= '0;
			lim_q     <= '0;
			k_q       <= '0;
			carry_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						cnt_q <= cnt_next;
						if (!store_ok) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							k_q <= '0;
							if (cnt_next >= CNT_W'(2)) begin
								lim_q     <= IDX_W'(cnt_next - CNT_W'(1));
								swapped_q <= 1'b0;
								state_q   <= ST_RD0;
							end else begin
								state_q <= ST_ORD;
							end
						end
					end
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					carry_q <= rd_q;
					pos_q   <= IDX_W'(1);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (do_swap) begin
						swapped_q <= 1'b1;
					end else begin
						carry_q <= rd_q;
					end
					if (pos_q == lim_q) begin
						state_q <= ST_PEND;
					end else begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				ST_PEND: begin
					if (!swapped_q || lim_q == IDX_W'(1)) begin
						state_q <= ST_ORD;
					end else begin
						lim_q     <= lim_q - IDX_W'(1);
						swapped_q <= 1'b0;
						state_q   <= ST_RD0;
					end
				end
				ST_ORD: begin
					state_q <= ST_OSEND;
				end
				ST_OSEND: begin
					if (res_ready) begin
						if (last_res) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign ready     = state_q == ST_LOAD;
	assign res_valid = state_q == ST_OSEND;
	assign value_res = rd_q;
	assign last_res  = ({1'b0, k_q} + CNT_W'(1)) == cnt_q;
	assign overflow  = ovf_q;

endmodule

@@ rtl/core/dbsu_checker.sv @@
module dbsu_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            valid,
	input logic            ready,
	input dbsu_pkg::data_t value,
	input logic            last,
	input logic            res_valid,
	input logic            res_ready,
	input dbsu_pkg::data_t value_res,
	input logic            last_res,
	input logic            overflow
);
	import dbsu_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(value) && $stable(last))
		else $error("Input beat changed before it was taken.");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value_res) && $stable(last_res)
			&& $stable(overflow))
		else $error("Result beat changed before it was taken.");

	a_no_load_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !ready)
		else $error("Input accepted while results are pending.");

	a_last_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && last_res |=> !res_valid && ready)
		else $error("Unit did not return to loading after the final result.");

	a_idle_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("Result beat offered right after reset.");

endmodule

bind descending_bubble_sort_unit dbsu_checker u_dbsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (valid),
	.ready     (ready),
	.value     (value),
	.last      (last),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.value_res (value_res),
	.last_res  (last_res),
	.overflow  (overflow)
);
